>>> rtl/core/rbl_pkg.sv
// shared constants, types and state encodings of the bar level meter
`timescale 1ns / 1ps

package rbl_pkg;

	localparam int MAX_BARS_DEF = 64;
	localparam int MAX_SPB_DEF  = 4096;

	localparam int SAMPLE_W    = 16;
	localparam int BAR_IDX_W   = 6;
	localparam int INV_W       = 7;
	localparam int BAR_COUNT_W = 7;
	localparam int SPB_W       = 13;
	localparam int GAIN_W      = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int LEVEL_W     = 20;
	localparam int ROOT_W      = 16;
	localparam int MEAN_W      = 32;
	localparam int MUL_A_W     = 23;
	localparam int MUL_B_W     = 16;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int LEVEL_LSB   = 15;
	localparam int FRAC_W      = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BAR_COUNT       = 2'd0;
	localparam cfg_idx_t CFG_SAMPLES_PER_BAR = 2'd1;
	localparam cfg_idx_t CFG_GAIN            = 2'd2;

	localparam logic [BAR_COUNT_W-1:0] BAR_COUNT_RST = 7'd32;
	localparam logic [SPB_W-1:0]       SPB_RST       = 13'd1;
	localparam logic [GAIN_W-1:0]      GAIN_RST      = 12'd256;
	localparam logic [GAIN_W-1:0]      GAIN_MAX      = 12'd2560;
	localparam logic [MUL_B_W-1:0]     LEVEL_SCALE   = 16'd180;
	localparam logic [MUL_B_W-1:0]     DECAY_NUM     = 16'd123;
	localparam logic [INV_W-1:0]       INV_MAX       = 7'd127;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_ACC,
		ST_START,
		ST_DIV,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_CMP,
		ST_OUT,
		ST_FEND,
		ST_FILL
	} core_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_SQRT,
		DS_DONE
	} ds_phase_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_t;

endpackage

>>> rtl/core/rbl_if.sv
// valid/ready channels for samples in and bar levels out
`timescale 1ns / 1ps

interface rbl_in_if;
	import rbl_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_end;

	modport source(output valid, sample, frame_end, input ready);
	modport sink(input valid, sample, frame_end, output ready);
endinterface

interface rbl_out_if;
	import rbl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [BAR_IDX_W-1:0] bar_index;
	logic [INV_W-1:0]     inverted_level;
	logic                 last_bar;

	modport source(output valid, bar_index, inverted_level, last_bar, input ready);
	modport sink(input valid, bar_index, inverted_level, last_bar, output ready);
endinterface

>>> rtl/core/rbl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/rbl_divsqrt.sv
// iterative mean divider and integer square root on one shared subtractor
`timescale 1ns / 1ps

module rbl_divsqrt #(
	parameter int SUM_W = 43,
	parameter int CNT_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   num,
	input  logic [CNT_W-1:0]   den,
	output rbl_pkg::root_t     res
);
	import rbl_pkg::*;

	localparam int SQ_REM_W = ROOT_W + 1;
	localparam int SQ_T_W   = SQ_REM_W + 2;
	localparam int SUB_W    = ((CNT_W + 1) > SQ_T_W) ? (CNT_W + 1) : SQ_T_W;
	localparam int STEP_W   = $clog2(SUM_W);

	ds_phase_t phase_q, phase_d;

	logic [SUM_W-1:0]    num_q;
	logic [CNT_W-1:0]    den_q;
	logic [CNT_W-1:0]    rem_q;
	logic [MEAN_W-1:0]   x_q;
	logic [SQ_REM_W-1:0] sq_rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   step_q;

	logic [SUB_W-1:0]    sub_a, sub_b;
	logic [SUB_W:0]      sub_diff;
	logic                sub_ge;
	logic [CNT_W:0]      div_t;
	logic [SQ_T_W-1:0]   sq_t;
	logic [SQ_T_W-1:0]   sq_d;
	logic [SUM_W-1:0]    num_nxt;
	logic [63:0]         quo_ext;
	logic                div_last, sq_last;

	// the one subtractor: quotient digit or root digit trial
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[SUB_W];

	assign div_t    = {rem_q, num_q[SUM_W-1]};
	assign sq_t     = {sq_rem_q, x_q[MEAN_W-1 -: 2]};
	assign sq_d     = {1'b0, root_q, 2'b01};
	assign num_nxt  = {num_q[SUM_W-2:0], sub_ge};
	assign quo_ext  = 64'(num_nxt);
	assign div_last = (step_q == STEP_W'(SUM_W - 1));
	assign sq_last  = (step_q == STEP_W'(ROOT_W - 1));

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			DS_IDLE: if (start) phase_d = DS_DIV;
			DS_DIV:  if (div_last) phase_d = DS_SQRT;
			DS_SQRT: if (sq_last) phase_d = DS_DONE;
			DS_DONE: phase_d = DS_IDLE;
			default: phase_d = DS_IDLE;
		endcase
	end

	always_comb begin
		sub_a = '0;
		sub_b = '0;
		unique case (phase_q)
			DS_DIV: begin
				sub_a = SUB_W'(div_t);
				sub_b = SUB_W'(den_q);
			end
			DS_SQRT: begin
				sub_a = SUB_W'(sq_t);
				sub_b = SUB_W'(sq_d);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
		res.done = (phase_q == DS_DONE);
		res.root = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DS_IDLE;
			step_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q != phase_d || phase_q == DS_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			DS_IDLE: begin
				if (start) begin
					num_q <= num;
					den_q <= den;
					rem_q <= '0;
				end
			end
			DS_DIV: begin
				num_q <= num_nxt;
				rem_q <= sub_ge ? sub_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
				if (div_last) begin
					// mean never exceeds a full-scale square, so it fits the root input
					x_q      <= quo_ext[MEAN_W-1:0];
					sq_rem_q <= '0;
					root_q   <= '0;
				end
			end
			DS_SQRT: begin
				x_q      <= {x_q[MEAN_W-3:0], 2'b00};
				sq_rem_q <= sub_ge ? sub_diff[SQ_REM_W-1:0] : sq_t[SQ_REM_W-1:0];
				root_q   <= {root_q[ROOT_W-2:0], sub_ge};
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/core/rms_bar_level_meter_core.sv
// bar level meter: one shared multiplier plus a divide/root unit under a sequencer
// a sample that completes no bar nor frame passes ST_SQR, ST_ACC, ST_FEND, then ready again
// a completing sample's result comes from the bit-serial divider (SUM_W steps) and the
// 16-step root on one subtractor, then the multiplier steps ST_M1 to ST_M3 and ST_CMP
// after an early frame end the remaining bars come out one per cycle while levels.ready is high
// async active-low reset; stored levels read as zero through per-bar valid bits, no sweep
`timescale 1ns / 1ps

module rms_bar_level_meter_core #(
	parameter int MAX_BARS            = rbl_pkg::MAX_BARS_DEF,
	parameter int MAX_SAMPLES_PER_BAR = rbl_pkg::MAX_SPB_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rbl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rbl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rbl_in_if.sink                           samples,
	rbl_out_if.source                        levels
);
	import rbl_pkg::*;

	localparam int CUR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int NB_W  = $clog2(MAX_BARS + 1);
	localparam int CNT_W = $clog2(MAX_SAMPLES_PER_BAR + 1);
	localparam int SUM_W = 31 + $clog2(MAX_SAMPLES_PER_BAR);

	core_state_t state_q, state_d;

	logic [BAR_COUNT_W-1:0] bar_count_q;
	logic [SPB_W-1:0]       spb_q;
	logic [GAIN_W-1:0]      gain_q;

	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CUR_W-1:0]       cur_q;
	logic                   done_q;
	logic                   fend_q;
	logic [MAX_BARS-1:0]    valid_q;

	logic [SAMPLE_W-1:0]    mag_q;
	logic [PROD_W-1:0]      prod_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [INV_W-1:0]       inv_q;

	logic [NB_W-1:0]        nbars;
	logic [CNT_W-1:0]       spb_eff;
	logic [GAIN_W-1:0]      gain_eff;
	logic [CNT_W:0]         cnt_inc;
	logic                   bar_full;
	logic [31:0]            cur_ext, cur_nxt_ext;
	logic                   last_cur, is_last;
	logic [SAMPLE_W-1:0]    mag;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [LEVEL_W-1:0]     ram_rdata, prev_level, held, fin_level;
	logic [LEVEL_W-FRAC_W-1:0] whole;
	logic                   ram_we, ds_start;
	logic                   cfg_bar_wr;
	root_t                  ds_res;

	rbl_ram #(
		.WIDTH(LEVEL_W),
		.DEPTH(MAX_BARS)
	) u_levels (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (fin_level),
		.raddr (cur_q),
		.rdata (ram_rdata)
	);

	rbl_divsqrt #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_ds (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.num    (sum_q),
		.den    (cnt_q),
		.res    (ds_res)
	);

	// effective register values
	always_comb begin
		if (bar_count_q == '0) begin
			nbars = NB_W'(1);
		end else if (32'(bar_count_q) > MAX_BARS) begin
			nbars = NB_W'(MAX_BARS);
		end else begin
			nbars = NB_W'(bar_count_q);
		end
		if (spb_q == '0) begin
			spb_eff = CNT_W'(1);
		end else if (32'(spb_q) > MAX_SAMPLES_PER_BAR) begin
			spb_eff = CNT_W'(MAX_SAMPLES_PER_BAR);
		end else begin
			spb_eff = CNT_W'(spb_q);
		end
		gain_eff = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
	end

	assign cfg_bar_wr  = cfg_we && (cfg_index == CFG_BAR_COUNT);
	assign cnt_inc     = {1'b0, cnt_q} + 1'b1;
	assign bar_full    = 32'(cnt_inc) >= 32'(spb_eff);
	assign cur_ext     = 32'(cur_q);
	assign cur_nxt_ext = cur_ext + 32'd1;
	assign last_cur    = cur_nxt_ext >= 32'(nbars);
	assign is_last     = cur_nxt_ext == 32'(nbars);

	assign mag = samples.sample[SAMPLE_W-1] ? (~samples.sample + 1'b1) : samples.sample;

	// peak hold against the decayed stored level
	assign prev_level = valid_q[cur_q] ? ram_rdata : '0;
	assign held       = prod_q[FRAC_W +: LEVEL_W];
	assign fin_level  = (held > level_q) ? held : level_q;
	assign whole      = fin_level[LEVEL_W-1:FRAC_W];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (samples.valid) state_d = ST_SQR;
			ST_SQR:   state_d = ST_ACC;
			ST_ACC:   state_d = (!done_q && bar_full) ? ST_START : ST_FEND;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (ds_res.done) state_d = ST_M1;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = ST_M3;
			ST_M3:    state_d = ST_CMP;
			ST_CMP:   state_d = ST_OUT;
			ST_OUT:   if (levels.ready) state_d = ST_FEND;
			ST_FEND: begin
				priority if (!fend_q || done_q) state_d = ST_IDLE;
				else if (cnt_q != '0)          state_d = ST_START;
				else                            state_d = ST_FILL;
			end
			ST_FILL:  if (levels.ready && last_cur) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = (state_q == ST_IDLE);
		levels.valid  = (state_q == ST_OUT) || (state_q == ST_FILL);
		ds_start      = (state_q == ST_START);
		ram_we        = (state_q == ST_CMP);
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_SQR: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = mag_q;
			end
			ST_M1: begin
				mul_a = MUL_A_W'(ds_res.root);
				mul_b = LEVEL_SCALE;
			end
			ST_M2: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(gain_eff);
			end
			ST_M3: begin
				mul_a = MUL_A_W'(prev_level);
				mul_b = DECAY_NUM;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign levels.bar_index      = cur_ext[BAR_IDX_W-1:0];
	assign levels.inverted_level = (state_q == ST_FILL) ? INV_MAX : inv_q;
	assign levels.last_bar       = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bar_count_q <= BAR_COUNT_RST;
			spb_q       <= SPB_RST;
			gain_q      <= GAIN_RST;
			sum_q       <= '0;
			cnt_q       <= '0;
			cur_q       <= '0;
			done_q      <= 1'b0;
			fend_q      <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BAR_COUNT:       bar_count_q <= cfg_wdata[BAR_COUNT_W-1:0];
					CFG_SAMPLES_PER_BAR: spb_q <= cfg_wdata[SPB_W-1:0];
					CFG_GAIN:            gain_q <= cfg_wdata[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			if (cfg_bar_wr) begin
				valid_q <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
				cur_q   <= '0;
				done_q  <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: if (samples.valid) fend_q <= samples.frame_end;
					ST_ACC: begin
						if (!done_q) begin
							sum_q <= sum_q + SUM_W'(prod_q[2*SAMPLE_W-1:0]);
							cnt_q <= cnt_inc[CNT_W-1:0];
						end
					end
					ST_CMP: valid_q[cur_q] <= 1'b1;
					ST_OUT: begin
						if (levels.ready) begin
							sum_q  <= '0;
							cnt_q  <= '0;
							cur_q  <= cur_nxt_ext[CUR_W-1:0];
							done_q <= last_cur;
						end
					end
					ST_FEND: begin
						// frame restarts here when nothing is left to emit
						if (fend_q && done_q) begin
							sum_q  <= '0;
							cnt_q  <= '0;
							cur_q  <= '0;
							done_q <= 1'b0;
						end
					end
					ST_FILL: begin
						if (levels.ready) begin
							if (last_cur) begin
								sum_q  <= '0;
								cnt_q  <= '0;
								cur_q  <= '0;
								done_q <= 1'b0;
							end else begin
								cur_q <= cur_nxt_ext[CUR_W-1:0];
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			mag_q <= mag;
		end
		if (state_q == ST_SQR || state_q == ST_M1 || state_q == ST_M2 || state_q == ST_M3) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (state_q == ST_M3) begin
			level_q <= prod_q[LEVEL_LSB +: LEVEL_W];
		end
		if (state_q == ST_CMP) begin
			inv_q <= (whole > (LEVEL_W-FRAC_W)'(INV_MAX)) ? '0
			         : (INV_MAX - whole[INV_W-1:0]);
		end
	end
endmodule

>>> rtl/core/rbl_checker.sv
// port-level checks on the bar level meter, bound to the top level
`timescale 1ns / 1ps

module rbl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [rbl_pkg::BAR_IDX_W-1:0]   bar_index,
	input logic [rbl_pkg::INV_W-1:0]       inverted_level,
	input logic                            last_bar
);
	import rbl_pkg::*;

	// input ready drops right after every accepted sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken again right after an accept");

	// no new sample while a level is pending
	a_no_take_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a level word is pending");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bar_index)
			&& $stable(inverted_level) && $stable(last_bar))
		else $error("stalled level word changed or dropped");
endmodule

bind rms_bar_level_meter_core rbl_checker u_rbl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (levels.valid),
	.out_ready      (levels.ready),
	.bar_index      (levels.bar_index),
	.inverted_level (levels.inverted_level),
	.last_bar       (levels.last_bar)
);
